// ===== hw/rtl/cursor_ordered_list_defines.svh =====
// ----------------------------------------------------------------------------
// cursor ordered list assertion macros
// shared property shapes for the list sequencer and its top level
// ----------------------------------------------------------------------------
`ifndef CURSOR_ORDERED_LIST_DEFINES_SVH
`define CURSOR_ORDERED_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define COL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define COL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/col_pkg.sv =====
// ----------------------------------------------------------------------------
// col_pkg
// shared types and constants of the cursor ordered list
// ----------------------------------------------------------------------------
package col_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // beat field widths
  localparam int FUNC_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int CURSOR_W = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_START    = 4'd0,
    FN_END      = 4'd1,
    FN_LASTSLOT = 4'd2,
    FN_ADVANCE  = 4'd3,
    FN_RETREAT  = 4'd4,
    FN_INSERT   = 4'd5,
    FN_ATTACH   = 4'd6,
    FN_REMOVE   = 4'd7,
    FN_INSFRONT = 4'd8,
    FN_APPEND   = 4'd9,
    FN_REMFRONT = 4'd10,
    FN_READCUR  = 4'd11,
    FN_READIDX  = 4'd12
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_CUR = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_CLOSE,
    S_FLUSH,
    S_PUT,
    S_READ,
    S_RDWAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_W-1:0]    read_value;
    logic [COUNT_W-1:0]    entry_count;
    logic [CURSOR_W-1:0]   cursor_position;
    logic                  has_current;
  } res_t;

endpackage

// ===== hw/rtl/cursor_ordered_list.sv =====
// accept to out_tvalid: cursor moves, errors and removing the last entry go straight to S_DONE,
// a put with no shift passes S_PUT, a read S_READ and S_RDWAIT, an insert of k entries S_OPEN,
// S_FLUSH and S_PUT, a remove S_CLOSE and S_FLUSH; worst case: insert at front of CAPACITY-1
// entries; the next beat is taken the cycle after the result is handed to the output register
// shifts go one entry a cycle through the single write port of the entry ram
// reset (rst_n low, synchronous) empties the list and puts the cursor at 0; ram not cleared
// ----------------------------------------------------------------------------
// cursor_ordered_list
// fixed-capacity ordered list with a cursor, stream in and stream out
// ----------------------------------------------------------------------------
`include "cursor_ordered_list_defines.svh"

module cursor_ordered_list #(
  parameter int CAPACITY   = col_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = col_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // entry_value [31:0], read_index [36:32]
  input  logic [col_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func [3:0]
  input  logic [col_pkg::FUNC_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status [1:0], read_value [33:2], entry_count [39:34],
  // cursor_position [44:40], has_current [45]
  output logic [col_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic          start;
  logic          res_valid;
  logic          res_ready;
  col_pkg::res_t res;

  logic                            out_valid_r, out_valid_nxt;
  logic [col_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign start = in_tvalid && in_tready;

  col_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .ready     (in_tready),
    .op_func   (in_tuser),
    .op_value  (in_tdata[31:0]),
    .op_index  (in_tdata[36:32]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the sequencer as soon as the beat is parked
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, res.has_current, res.cursor_position, res.entry_count,
                       res.read_value, res.status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `COL_ASSERT_NEXT(a_out_load, res_valid && res_ready, out_tvalid, "result beat not loaded")
  `COL_ASSERT_IMPL(a_busy_no_take, out_tvalid && !out_tready, !res_ready, "output overwritten")

endmodule

// ===== hw/rtl/col_ram.sv =====
// ----------------------------------------------------------------------------
// col_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module col_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/col_ctrl.sv =====
// ----------------------------------------------------------------------------
// col_ctrl
// list sequencer: decodes one operation, then moves entries one per cycle
// through the entry ram and builds the result
// ----------------------------------------------------------------------------
`include "cursor_ordered_list_defines.svh"

module col_ctrl #(
  parameter int CAPACITY   = col_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = col_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         ready,
  input  logic [col_pkg::FUNC_W-1:0]   op_func,
  input  logic [col_pkg::VALUE_W-1:0]  op_value,
  input  logic [col_pkg::INDEX_W-1:0]  op_index,
  output logic                         res_valid,
  input  logic                         res_ready,
  output col_pkg::res_t                res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  col_pkg::seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      cursor_r, cursor_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      stop_r, stop_nxt;
  logic                  put_r, put_nxt;
  logic [IDX_W-1:0]      put_addr_r, put_addr_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]      wr_addr_r, wr_addr_nxt;
  col_pkg::res_t         res_r, res_nxt;

  // decode results
  col_pkg::seq_state_t dec_next;
  col_pkg::status_t    dec_status;
  logic [CNT_W-1:0]    dec_count;
  logic [IDX_W-1:0]    dec_cursor;
  logic [IDX_W-1:0]    dec_src;
  logic [IDX_W-1:0]    dec_stop;
  logic                dec_put;
  logic [IDX_W-1:0]    dec_put_addr;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  col_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  // operation decode against the current count and cursor
  always_comb begin
    logic             has_cur;
    logic             full;
    logic             do_open;
    logic             do_close;
    logic             do_read;
    logic [CNT_W-1:0] pos;
    logic [IDX_W-1:0] rd_addr;

    has_cur  = CNT_W'(cursor_r) < count_r;
    full     = count_r == CNT_W'(CAPACITY);
    do_open  = 1'b0;
    do_close = 1'b0;
    do_read  = 1'b0;
    pos      = '0;
    rd_addr  = cursor_r;

    dec_status   = col_pkg::ST_OK;
    dec_count    = count_r;
    dec_cursor   = cursor_r;
    dec_next     = col_pkg::S_DONE;
    dec_src      = '0;
    dec_stop     = '0;
    dec_put      = 1'b0;
    dec_put_addr = '0;

    case (col_pkg::func_t'(op_func))
      col_pkg::FN_START: begin
        dec_cursor = '0;
      end
      col_pkg::FN_END: begin
        dec_cursor = (count_r != '0) ? IDX_W'(count_r - 1'b1) : '0;
      end
      col_pkg::FN_LASTSLOT: begin
        dec_cursor = IDX_W'(CAPACITY - 1);
      end
      col_pkg::FN_ADVANCE: begin
        if (!has_cur) begin
          dec_status = col_pkg::ST_NO_CUR;
        end else if (cursor_r != IDX_W'(CAPACITY - 1)) begin
          dec_cursor = cursor_r + 1'b1;
        end
      end
      col_pkg::FN_RETREAT: begin
        if (cursor_r != '0) begin
          dec_cursor = cursor_r - 1'b1;
        end
      end
      col_pkg::FN_INSERT: begin
        if (full) begin
          dec_status = col_pkg::ST_FULL;
        end else if (has_cur) begin
          do_open   = 1'b1;
          pos       = CNT_W'(cursor_r);
          dec_count = count_r + 1'b1;
        end else begin
          do_open    = 1'b1;
          pos        = count_r;
          dec_cursor = IDX_W'(count_r);
          dec_count  = count_r + 1'b1;
        end
      end
      col_pkg::FN_ATTACH: begin
        if (full) begin
          dec_status = col_pkg::ST_FULL;
        end else if (has_cur) begin
          do_open    = 1'b1;
          pos        = CNT_W'(cursor_r) + 1'b1;
          dec_cursor = cursor_r + 1'b1;
          dec_count  = count_r + 1'b1;
        end else begin
          do_open    = 1'b1;
          pos        = count_r;
          dec_cursor = IDX_W'(count_r);
          dec_count  = count_r + 1'b1;
        end
      end
      col_pkg::FN_REMOVE: begin
        if (!has_cur) begin
          dec_status = col_pkg::ST_NO_CUR;
        end else begin
          do_close  = 1'b1;
          pos       = CNT_W'(cursor_r);
          dec_count = count_r - 1'b1;
        end
      end
      col_pkg::FN_INSFRONT: begin
        if (full) begin
          dec_status = col_pkg::ST_FULL;
        end else begin
          do_open    = 1'b1;
          pos        = '0;
          dec_cursor = '0;
          dec_count  = count_r + 1'b1;
        end
      end
      col_pkg::FN_APPEND: begin
        if (full) begin
          dec_status = col_pkg::ST_FULL;
        end else begin
          do_open    = 1'b1;
          pos        = count_r;
          dec_cursor = IDX_W'(count_r);
          dec_count  = count_r + 1'b1;
        end
      end
      col_pkg::FN_REMFRONT: begin
        if (count_r == '0) begin
          dec_status = col_pkg::ST_NO_CUR;
        end else begin
          do_close   = 1'b1;
          pos        = '0;
          dec_cursor = '0;
          dec_count  = count_r - 1'b1;
        end
      end
      col_pkg::FN_READCUR: begin
        if (!has_cur) begin
          dec_status = col_pkg::ST_NO_CUR;
        end else begin
          do_read = 1'b1;
          rd_addr = cursor_r;
        end
      end
      col_pkg::FN_READIDX: begin
        if (int'(op_index) >= int'(count_r)) begin
          dec_status = col_pkg::ST_RANGE;
        end else begin
          do_read = 1'b1;
          rd_addr = IDX_W'(op_index);
        end
      end
      default: begin
      end
    endcase

    if (do_open) begin
      dec_put      = 1'b1;
      dec_put_addr = IDX_W'(pos);
      if (pos == count_r) begin
        dec_next = col_pkg::S_PUT;
      end else begin
        // shift the tail up, top entry first
        dec_next = col_pkg::S_OPEN;
        dec_src  = IDX_W'(count_r - 1'b1);
        dec_stop = IDX_W'(pos);
      end
    end else if (do_close) begin
      if (pos + 1'b1 != count_r) begin
        // shift the tail down, lowest entry first
        dec_next = col_pkg::S_CLOSE;
        dec_src  = IDX_W'(pos + 1'b1);
        dec_stop = IDX_W'(count_r - 1'b1);
      end
    end else if (do_read) begin
      dec_next = col_pkg::S_READ;
      dec_src  = rd_addr;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      col_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = dec_next;
        end
      end
      col_pkg::S_OPEN,
      col_pkg::S_CLOSE: begin
        if (src_r == stop_r) begin
          state_nxt = col_pkg::S_FLUSH;
        end
      end
      col_pkg::S_FLUSH: begin
        state_nxt = put_r ? col_pkg::S_PUT : col_pkg::S_DONE;
      end
      col_pkg::S_PUT:    state_nxt = col_pkg::S_DONE;
      col_pkg::S_READ:   state_nxt = col_pkg::S_RDWAIT;
      col_pkg::S_RDWAIT: state_nxt = col_pkg::S_DONE;
      col_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = col_pkg::S_IDLE;
        end
      end
      default: state_nxt = col_pkg::S_IDLE;
    endcase
  end

  // outputs and ram port
  always_comb begin
    ready     = state_r == col_pkg::S_IDLE;
    res_valid = state_r == col_pkg::S_DONE;
    res       = res_r;
    ram_we    = wr_pend_r || (state_r == col_pkg::S_PUT);
    ram_waddr = (state_r == col_pkg::S_PUT) ? put_addr_r : wr_addr_r;
    ram_wdata = (state_r == col_pkg::S_PUT) ? val_r : ram_rdata;
  end

  // datapath registers
  always_comb begin
    count_nxt    = count_r;
    cursor_nxt   = cursor_r;
    src_nxt      = src_r;
    stop_nxt     = stop_r;
    put_nxt      = put_r;
    put_addr_nxt = put_addr_r;
    val_nxt      = val_r;
    wr_pend_nxt  = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    res_nxt      = res_r;

    case (state_r)
      col_pkg::S_IDLE: begin
        if (start) begin
          count_nxt    = dec_count;
          cursor_nxt   = dec_cursor;
          src_nxt      = dec_src;
          stop_nxt     = dec_stop;
          put_nxt      = dec_put;
          put_addr_nxt = dec_put_addr;
          val_nxt      = DATA_WIDTH'(op_value);
          res_nxt.status          = dec_status;
          res_nxt.read_value      = '0;
          res_nxt.entry_count     = col_pkg::COUNT_W'(dec_count);
          res_nxt.cursor_position = col_pkg::CURSOR_W'(dec_cursor);
          res_nxt.has_current     = CNT_W'(dec_cursor) < dec_count;
        end
      end
      col_pkg::S_OPEN: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = src_r + 1'b1;
        if (src_r != stop_r) begin
          src_nxt = src_r - 1'b1;
        end
      end
      col_pkg::S_CLOSE: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = src_r - 1'b1;
        if (src_r != stop_r) begin
          src_nxt = src_r + 1'b1;
        end
      end
      col_pkg::S_RDWAIT: begin
        res_nxt.read_value = col_pkg::VALUE_W'(ram_rdata);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= col_pkg::S_IDLE;
      count_r   <= '0;
      cursor_r  <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    stop_r     <= stop_nxt;
    put_r      <= put_nxt;
    put_addr_r <= put_addr_nxt;
    val_r      <= val_nxt;
    wr_addr_r  <= wr_addr_nxt;
    res_r      <= res_nxt;
  end

  `COL_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `COL_ASSERT_IMPL(a_idle_no_write, state_r == col_pkg::S_IDLE, !wr_pend_r, "write pending in idle")
  `COL_ASSERT_IMPL(a_open_range, state_r == col_pkg::S_OPEN, src_r >= stop_r, "open shift overran")
  `COL_ASSERT_NEXT(a_full_holds, start && ready && dec_status == col_pkg::ST_FULL, count_r == $past(count_r), "full list changed")

endmodule

// ===== tb/col_checker.sv =====
// ----------------------------------------------------------------------------
// col_checker
// watches both streams of the cursor ordered list, keeps its own copy of the
// list contents, count and cursor, and compares every result beat field by
// field with the oldest predicted result
// ----------------------------------------------------------------------------
module col_checker
  import col_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t             status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;
    logic [CURSOR_W-1:0] cursor_position;
    logic                has_current;
  } list_result_t;

  logic [VALUE_W-1:0] list_mem [CAPACITY_DEF];
  int                 list_count = 0;
  int                 list_cursor = 0;
  int                 err_count = 0;
  list_result_t       result_q [$];

  assign mismatches = err_count;

  // move entries pos..count-1 up by one and put val at pos
  function automatic void open_slot(int pos, logic [VALUE_W-1:0] val);
    for (int i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
    list_mem[pos] = val;
    list_count++;
  endfunction

  // close the hole at pos by moving the later entries down
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
    list_count--;
  endfunction

  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] fn,
                                                 logic [VALUE_W-1:0] val,
                                                 logic [INDEX_W-1:0] idx);
    list_result_t r;
    bit           cur;
    bit           full;
    r.status     = ST_OK;
    r.read_value = '0;
    cur  = list_cursor < list_count;
    full = list_count >= CAPACITY_DEF;
    case (fn)
      FN_START:    list_cursor = 0;
      FN_END:      list_cursor = (list_count != 0) ? list_count - 1 : 0;
      FN_LASTSLOT: list_cursor = CAPACITY_DEF - 1;
      FN_ADVANCE: begin
        if (!cur) r.status = ST_NO_CUR;
        else if (list_cursor != CAPACITY_DEF - 1) list_cursor++;
      end
      FN_RETREAT: begin
        if (list_cursor != 0) list_cursor--;
      end
      FN_INSERT, FN_ATTACH, FN_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (cur && fn == FN_INSERT) begin
          open_slot(list_cursor, val);
        end else if (cur && fn == FN_ATTACH) begin
          open_slot(list_cursor + 1, val);
          list_cursor++;
        end else begin
          // no current item: insert and attach fall back to append
          open_slot(list_count, val);
          list_cursor = list_count - 1;
        end
      end
      FN_INSFRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          open_slot(0, val);
          list_cursor = 0;
        end
      end
      FN_REMOVE: begin
        if (!cur) r.status = ST_NO_CUR;
        else drop_slot(list_cursor);
      end
      FN_REMFRONT: begin
        if (list_count == 0) begin
          r.status = ST_NO_CUR;
        end else begin
          drop_slot(0);
          list_cursor = 0;
        end
      end
      FN_READCUR: begin
        if (!cur) r.status = ST_NO_CUR;
        else r.read_value = list_mem[list_cursor];
      end
      FN_READIDX: begin
        if (idx >= list_count) r.status = ST_RANGE;
        else r.read_value = list_mem[idx];
      end
      default: ;
    endcase
    r.entry_count     = list_count[COUNT_W-1:0];
    r.cursor_position = list_cursor[CURSOR_W-1:0];
    r.has_current     = list_cursor < list_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want,
                             logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_count  = 0;
      list_cursor = 0;
      result_q.delete();
    end else begin
      // the result side goes first: a beat leaving now belongs to an older op
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                   $time, out_tdata);
          err_count++;
        end else begin
          want = result_q.pop_front();
          check_field("status", VALUE_W'(want.status),
                      VALUE_W'(out_tdata[0 +: STATUS_W]));
          check_field("read_value", want.read_value, out_tdata[2 +: VALUE_W]);
          check_field("entry_count", VALUE_W'(want.entry_count),
                      VALUE_W'(out_tdata[34 +: COUNT_W]));
          check_field("cursor_position", VALUE_W'(want.cursor_position),
                      VALUE_W'(out_tdata[40 +: CURSOR_W]));
          check_field("has_current", VALUE_W'(want.has_current),
                      VALUE_W'(out_tdata[45]));
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(apply_list_op(in_tuser, in_tdata[0 +: VALUE_W],
                                         in_tdata[VALUE_W +: INDEX_W]));
    end
    awaiting <= result_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives directed and random list operations into the cursor ordered list
// with random gaps and back-pressure; a checker predicts every result beat
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import col_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_A = 4'd13;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 4'd14;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 4'd15;
  localparam int RANDOM_OPS = 1925;
  localparam int LONG_HOLD  = 400;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} op_mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatches;
  int                     awaiting;

  int tx_quiet = 0;
  int rx_quiet = 0;
  bit hold_request = 0;

  cursor_ordered_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  col_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // idle cycles before the next beat, with occasional runs of back-to-back beats
  function automatic int draw_gap(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(op_mix_t mix);
    int                r;
    logic [FUNC_W-1:0] fn;
    r  = $urandom_range(0, 99);
    fn = FUNC_W'($urandom_range(0, 15));
    if (mix == MIX_GROW && r < 60) begin
      case ($urandom_range(0, 3))
        0:       fn = FN_INSERT;
        1:       fn = FN_ATTACH;
        2:       fn = FN_INSFRONT;
        default: fn = FN_APPEND;
      endcase
    end else if (mix == MIX_SHRINK && r < 55) begin
      fn = $urandom_range(0, 1) ? FN_REMOVE : FN_REMFRONT;
    end
    return fn;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] val,
                         logic [INDEX_W-1:0] idx);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-VALUE_W-INDEX_W){1'b0}}, idx, val};
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering beats until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(rx_quiet);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    op_mix_t mix;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: moves, error paths, end on empty
    send_op(FN_START, '0, '0);
    send_op(FN_END, '0, '0);
    send_op(FN_READCUR, '0, '0);
    send_op(FN_ADVANCE, '0, '0);
    send_op(FN_RETREAT, '0, '0);
    send_op(FN_REMOVE, '0, '0);
    send_op(FN_REMFRONT, '0, '0);
    send_op(FN_READIDX, '0, '0);
    // insert and attach with no current item append
    send_op(FN_INSERT, 32'h0000_0000, '0);
    send_op(FN_LASTSLOT, '0, '0);
    send_op(FN_ATTACH, 32'hffff_ffff, '0);
    send_op(FN_INSFRONT, 32'ha5a5_a5a5, '0);
    send_op(FN_APPEND, 32'h5a5a_5a5a, '0);
    send_op(FN_RETREAT, '0, '0);
    send_op(FN_INSERT, 32'h1234_5678, '0);
    send_op(FN_ATTACH, 32'h8000_0001, '0);
    send_op(FN_READCUR, '0, '0);
    send_op(FN_READIDX, '0, 5'd31);
    send_op(FN_READIDX, '0, 5'd4);
    // remove front while the cursor is past the items
    send_op(FN_LASTSLOT, '0, '0);
    send_op(FN_REMFRONT, '0, '0);
    send_op(FN_ADVANCE, '0, '0);
    send_op(FN_REMOVE, '0, '0);
    send_op(FN_END, '0, '0);
    send_op(FN_READIDX, '0, 5'd0);
    send_op(FN_SPARE_A, 32'hdead_beef, 5'd7);
    send_op(FN_SPARE_B, '0, '0);
    send_op(FN_SPARE_C, '1, '1);
    drain();

    mix = MIX_GROW;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) mix = op_mix_t'($urandom_range(0, 2));
      if (n == 300) hold_request = 1;
      if (n == 700 || n == 1400) drain();
      send_op(pick_func(mix), pick_value(),
              INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                             : $urandom_range(0, 7)));
    end
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/col_pkg.sv
hw/rtl/col_ram.sv
hw/rtl/col_ctrl.sv
hw/rtl/cursor_ordered_list.sv
tb/col_checker.sv
tb/testbench.sv
